/* rtl/lut4dp_pkg.sv */
// ============================================================================
// lut4dp_pkg
// Shared types, constants and code decoding for the LUT4 decode dot product.
// ============================================================================
package lut4dp_pkg;

    // Field and register widths
    localparam int QUERY_W = 8;
    localparam int CODE_W  = 2;
    localparam int LEVEL_W = 8;
    localparam int PROD_W  = QUERY_W + LEVEL_W + 1;
    localparam int SUM_W   = 48;
    localparam int DOT_W   = 64;
    localparam int TABLE_W = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAGNITUDE_TABLE = 2'd0,
        REG_LAYOUT_MODE     = 2'd1
    } cfg_reg_t;

    // Layout modes
    localparam logic LAYOUT_SPLIT  = 1'b0;
    localparam logic LAYOUT_NIBBLE = 1'b1;

    // Sign flip applied to the decoded level
    localparam logic [LEVEL_W-1:0] LEVEL_BIAS = 8'h80;

    // Decode a 4-bit code to a level byte. Bit 1 of the high half always
    // carries the sign; the table row bit depends on the layout.
    function automatic logic [LEVEL_W-1:0] decode_level(
        input logic [TABLE_W-1:0] table_bits,
        input logic               layout,
        input logic [CODE_W-1:0]  code_hi,
        input logic [CODE_W-1:0]  code_lo
    );
        logic                positive;
        logic                row;
        logic [2:0]          idx;
        logic [LEVEL_W-1:0]  mag;
        positive = code_hi[1];
        row      = (layout == LAYOUT_NIBBLE) ? code_hi[0] : (code_hi[0] ^ ~code_hi[1]);
        idx      = {row, code_lo};
        mag      = table_bits[idx*LEVEL_W +: LEVEL_W];
        return positive ? mag : ~mag;
    endfunction

endpackage

/* rtl/lut4_decode_dot_product.sv */
// ============================================================================
// lut4_decode_dot_product
// Streaming int8 dot product with 4-bit codes decoded through a magnitude
// table, one dimension per transfer.
// ============================================================================
// The block takes one dimension in every cycle unless stalled: an accepted
// transfer lands in an input register, where its code is decoded and the
// biased level is multiplied by the query byte and added to the 48-bit
// running sum as the item moves on. On the transfer marked last_dim the
// correction is added and the result moves into an output register; the
// input side keeps flowing while that result waits, and stalls only when a
// second last item finds the output register still full.
// Configuration writes are always accepted and must be made while the block
// is idle.
module lut4_decode_dot_product (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lut4dp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lut4dp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lut4dp_pkg::QUERY_W-1:0] s_query_value,
    input  logic [lut4dp_pkg::CODE_W-1:0]         s_code_high,
    input  logic [lut4dp_pkg::CODE_W-1:0]         s_code_low,
    input  logic signed [lut4dp_pkg::DOT_W-1:0]   s_correction,
    input  logic                                  s_last_dim,
    // Result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lut4dp_pkg::DOT_W-1:0]   m_dot_value
);
    import lut4dp_pkg::*;

    // Configuration registers
    logic [TABLE_W-1:0]       table_reg;
    logic                     layout_reg;

    // Input register
    logic                     in_valid_reg;
    logic signed [QUERY_W-1:0] query_reg;
    logic [CODE_W-1:0]        code_high_reg;
    logic [CODE_W-1:0]        code_low_reg;
    logic signed [DOT_W-1:0]  correction_reg;
    logic                     last_reg;

    // Accumulator and output register
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     out_valid_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [DOT_W-1:0]  dot_next;

    logic                     advance;
    logic                     in_take;
    logic [LEVEL_W-1:0]       level;
    logic [LEVEL_W-1:0]       biased;
    logic signed [PROD_W-1:0] product;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_reg  <= '0;
            layout_reg <= LAYOUT_SPLIT;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MAGNITUDE_TABLE) begin
                table_reg <= cfg_data[TABLE_W-1:0];
            end
            if (cfg_index == REG_LAYOUT_MODE) begin
                layout_reg <= cfg_data[0];
            end
        end
    end

    // The held item moves on unless it is a last item and the output is full.
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            query_reg      <= s_query_value;
            code_high_reg  <= s_code_high;
            code_low_reg   <= s_code_low;
            correction_reg <= s_correction;
            last_reg       <= s_last_dim;
        end
    end

    // Decode, bias, multiply and accumulate.
    always_comb begin
        level    = decode_level(table_reg, layout_reg, code_high_reg, code_low_reg);
        biased   = level ^ LEVEL_BIAS;
        product  = PROD_W'(query_reg) * $signed({1'b0, biased});
        sum_next = sum_reg + SUM_W'(product);
        dot_next = correction_reg + DOT_W'(sum_next);
    end

    // Running sum, cleared once a vector's result has been formed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (advance) begin
            sum_reg <= last_reg ? '0 : sum_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            dot_reg <= dot_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_dot_value = dot_reg;

    // The sum restarts from zero after every last item.
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> (sum_reg == '0))
        else $error("running sum not cleared after last item");

    // Items that are not last never hold up the input side.
    a_no_stall_mid_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !last_reg) |-> s_ready)
        else $error("input stalled on an item that is not last");

    // A new result only appears when a last item has been processed.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(advance && last_reg))
        else $error("result appeared without a last item");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(advance && last_reg))
        else $error("pending result overwritten");

endmodule

/* dv/lut4_decode_dot_product_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// lut4_decode_dot_product_test
// Self-checking bench for the LUT4 decode dot product. A scoreboard class
// predicts each dot value from the transfers taken on the input channel and
// checks every transfer on the result channel against the oldest one waiting.
// Both channels idle at random, and the registers change between phases.
// ============================================================================
module lut4_decode_dot_product_test;
    import lut4dp_pkg::*;

    // Register indexes that the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [DOT_W-1:0] DOT_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DOT_W-1:0] DOT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Tracks the register copy and the running sum, and holds the dot values
    // still to come out of the block.
    class dot_tracker;
        logic [TABLE_W-1:0] mag_bits;
        logic               layout;
        logic [SUM_W-1:0]   running_sum;
        logic [DOT_W-1:0]   pending_dots[$];
        int unsigned        fail_count;

        function new();
            mag_bits    = '0;
            layout      = LAYOUT_SPLIT;
            running_sum = '0;
            fail_count  = 0;
        endfunction

        // Mirror a register write taken by the block.
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAGNITUDE_TABLE: mag_bits = data;
                REG_LAYOUT_MODE:     layout   = data[0];
                default: ;
            endcase
        endfunction

        // Decode one dimension, add its product, and note a dot on the last one.
        function void absorb_dimension(logic signed [QUERY_W-1:0] q, logic [CODE_W-1:0] hi,
                                       logic [CODE_W-1:0] lo, logic [DOT_W-1:0] corr,
                                       logic is_last);
            logic                      positive;
            logic                      coarse;
            logic [2:0]                slot;
            logic [LEVEL_W-1:0]        mag;
            logic [LEVEL_W-1:0]        biased;
            logic signed [PROD_W-1:0]  prod;
            positive = hi[1];
            if (layout == LAYOUT_NIBBLE) begin
                coarse = hi[0];
            end else begin
                coarse = hi[0] ^ ~positive;
            end
            slot   = {coarse, lo};
            mag    = mag_bits[slot*LEVEL_W +: LEVEL_W];
            biased = (positive ? mag : ~mag) ^ LEVEL_BIAS;
            prod   = q * $signed({1'b0, biased});
            running_sum = running_sum + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
            if (is_last) begin
                pending_dots.push_back(corr + {{(DOT_W-SUM_W){running_sum[SUM_W-1]}},
                                               running_sum});
                running_sum = '0;
            end
        endfunction

        // Compare one result transfer with the oldest dot waiting.
        function void check_dot(logic [DOT_W-1:0] actual);
            logic [DOT_W-1:0] wanted;
            if (pending_dots.size() == 0) begin
                $display("%0t: unexpected dot_value, expected none, actual %h", $time, actual);
                fail_count++;
            end else begin
                wanted = pending_dots.pop_front();
                if (actual !== wanted) begin
                    $display("%0t: dot_value mismatch, expected %h, actual %h",
                             $time, wanted, actual);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [QUERY_W-1:0] s_query_value;
    logic [CODE_W-1:0]         s_code_high;
    logic [CODE_W-1:0]         s_code_low;
    logic signed [DOT_W-1:0]   s_correction;
    logic                      s_last_dim;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DOT_W-1:0]   m_dot_value;

    dot_tracker board;
    logic       steady;
    int         items_sent;

    lut4_decode_dot_product uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_query_value (s_query_value),
        .s_code_high   (s_code_high),
        .s_code_low    (s_code_low),
        .s_correction  (s_correction),
        .s_last_dim    (s_last_dim),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dot_value   (m_dot_value)
    );

    // Clock with a 20 ns period.
    always #10 aclk = ~aclk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DOT_W-1:0] pick_correction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return DOT_MIN;
        if (r < 8) return DOT_MAX;
        if (r < 10) return '0;
        if (r < 12) return '1;
        return {$urandom, $urandom};
    endfunction

    // Offer one dimension and hold it until the transfer completes.
    task automatic send_dimension(input logic [QUERY_W-1:0] q, input logic [CODE_W-1:0] hi,
                                  input logic [CODE_W-1:0] lo, input logic [DOT_W-1:0] corr,
                                  input logic is_last);
        int gap;
        gap = pick_pause();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_query_value <= q;
        s_code_high   <= hi;
        s_code_low    <= lo;
        s_correction  <= corr;
        s_last_dim    <= is_last;
        do @(posedge aclk); while (!s_ready);
        board.absorb_dimension(q, hi, lo, corr, is_last);
        items_sent++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every dot to arrive, then let the pipeline drain.
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending_dots.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    // Result side: random stalls on m_ready.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_pause();
            end
        end
    end

    // Every result transfer is checked as it happens.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_dot(m_dot_value);
    end

    // Hard limit on the run time.
    initial begin
        #40_000_000;
        $display("FAIL lut4_decode_dot_product");
        $finish;
    end

    initial begin
        logic signed [QUERY_W-1:0] group_query[4];
        logic [DOT_W-1:0]          group_corr[4];
        logic [3:0]                code;
        logic [QUERY_W-1:0]        q;
        logic [TABLE_W-1:0]        tbl;
        int                        r;
        int                        phase_target;
        int                        phase_count;
        int                        len;

        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_query_value = '0;
        s_code_high   = '0;
        s_code_low    = '0;
        s_correction  = '0;
        s_last_dim    = 1'b0;
        m_ready       = 1'b0;
        steady        = 1'b0;
        items_sent    = 0;
        board         = new();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Split layout: all sixteen codes in vectors of four. Positive queries
        // against the largest correction and negative ones against the smallest
        // make the final addition wrap both ways.
        group_query[0] = 8'sd127;  group_corr[0] = DOT_MAX;
        group_query[1] = -8'sd128; group_corr[1] = DOT_MIN;
        group_query[2] = 8'sd0;    group_corr[2] = '0;
        group_query[3] = -8'sd1;   group_corr[3] = '1;
        write_register(REG_MAGNITUDE_TABLE, 64'h00FF_7F80_01FE_A55A);
        write_register(REG_LAYOUT_MODE, {{(CFG_DATA_W-1){1'b0}}, LAYOUT_SPLIT});
        for (int i = 0; i < 16; i++) begin
            code = i[3:0];
            send_dimension(group_query[i/4], code[3:2], code[1:0],
                           (i % 4 == 3) ? group_corr[i/4] : {$urandom, $urandom},
                           i % 4 == 3);
        end
        settle();

        // Nibble layout with junk above bit 0; undecoded indexes change nothing.
        write_register(REG_SPARE_A, {$urandom, $urandom});
        write_register(REG_SPARE_B, {$urandom, $urandom});
        write_register(REG_LAYOUT_MODE, {$urandom, $urandom} | 64'd1);
        for (int k = 0; k < 8; k++) begin
            code = {k[0], k[2:0]};
            send_dimension(8'($urandom_range(0, 255)), code[3:2], code[1:0],
                           {$urandom, $urandom}, k % 4 == 3);
        end
        settle();

        // A long vector with every product at its most negative; the smallest
        // correction then wraps the result.
        write_register(REG_MAGNITUDE_TABLE, {8{8'h7F}});
        write_register(REG_LAYOUT_MODE, {$urandom, $urandom} & ~64'd1);
        for (int i = 0; i < 320; i++) begin
            send_dimension(8'h80, {1'b1, 1'($urandom)}, 2'($urandom),
                           (i == 319) ? DOT_MIN : {$urandom, $urandom}, i == 319);
        end
        settle();

        // Random phases, each with its own register settings.
        while (items_sent < 1200) begin
            r = $urandom_range(0, 5);
            case (r)
                0: tbl = '0;
                1: tbl = '1;
                2: tbl = {8{8'h80}};
                3: tbl = {8{8'h7F}};
                default: tbl = {$urandom, $urandom};
            endcase
            write_register(REG_MAGNITUDE_TABLE, tbl);
            write_register(REG_LAYOUT_MODE, {$urandom, $urandom});
            if ($urandom_range(0, 3) == 0) begin
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                               {$urandom, $urandom});
            end
            steady       = ($urandom_range(0, 4) == 0);
            phase_target = $urandom_range(60, 140);
            phase_count  = 0;
            while (phase_count < phase_target) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 80)
                                                  : $urandom_range(1, 6);
                for (int d = 0; d < len; d++) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) q = 8'h80;
                    else if (r < 16) q = 8'h7F;
                    else q = 8'($urandom_range(0, 255));
                    code = 4'($urandom_range(0, 15));
                    send_dimension(q, code[3:2], code[1:0], pick_correction(), d == len - 1);
                end
                phase_count += len;
            end
            // Sometimes leave a vector open across the next register change.
            if ($urandom_range(0, 1) == 0) begin
                len = $urandom_range(1, 3);
                for (int d = 0; d < len; d++) begin
                    code = 4'($urandom_range(0, 15));
                    send_dimension(8'($urandom_range(0, 255)), code[3:2], code[1:0],
                                   pick_correction(), 1'b0);
                end
            end
            settle();
            steady = 1'b0;
        end

        // Close any open vector, then drain.
        send_dimension(8'($urandom_range(0, 255)), 2'($urandom), 2'($urandom),
                       pick_correction(), 1'b1);
        settle();
        if (board.pending_dots.size() != 0) begin
            $display("%0t: %0d dot values never arrived, expected %h, actual none",
                     $time, board.pending_dots.size(), board.pending_dots[0]);
            board.fail_count++;
        end
        if (board.fail_count == 0) begin
            $display("PASS lut4_decode_dot_product");
        end else begin
            $display("FAIL lut4_decode_dot_product");
        end
        $finish;
    end

endmodule
